@@ rtl/core/baf_pkg.sv @@
`default_nettype none
package baf_pkg;
	localparam int MAX_SIZE  = 512;
	localparam int RADIUS    = 3;
	localparam int WIN       = 2 * RADIUS + 1;
	localparam int AREA      = WIN * WIN;
	localparam int LINES     = 8;
	localparam int PIX_W     = 32;
	localparam int SIZE_W    = 10;
	localparam int POS_W     = 9;
	localparam int LINE_W    = 3;
	localparam int ADDR_W    = LINE_W + POS_W;
	localparam int DEPTH     = LINES * MAX_SIZE;
	localparam int CNT_W     = 19;
	localparam int ACC_W     = 38;
	localparam int MAG_W     = 37;
	localparam int HALF_W    = 19;
	localparam int RECIP_W   = 38;
	localparam int RECIP_SH  = 43;
	localparam int PROD_W    = 75;
	localparam int MUL_STEPS = 4;
	localparam int STEP_W    = 2;

	// ceil(2^43 / 49): exact floor quotient for any 37-bit magnitude
	localparam logic [RECIP_W-1:0] RECIP = 38'd179512102495;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic accept;
		logic clear_acc;
		logic gather;
		logic brd_rd;
		logic div_load;
		logic div_step;
		logic load_border;
		logic load_mean;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic interior;
		logic gather_last;
		logic div_done;
		logic slot_free;
	} status_t;
endpackage
`default_nettype wire

@@ rtl/core/baf_in_if.sv @@
`default_nettype none
interface baf_in_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [baf_pkg::PIX_W-1:0] pixel_value;
	modport source (output valid, output cmd, output pixel_value, input ready);
	modport sink   (input valid, input cmd, input pixel_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/baf_out_if.sv @@
`default_nettype none
interface baf_out_if;
	logic                      valid;
	logic                      ready;
	logic [baf_pkg::PIX_W-1:0] out_value;
	logic                      out_last;
	modport source (output valid, output out_value, output out_last, input ready);
	modport sink   (input valid, input out_value, input out_last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/baf_ram.sv @@
`default_nettype none
module baf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/baf_ctrl.sv @@
`default_nettype none
module baf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire baf_pkg::status_t sts,
	output      baf_pkg::cmd_t    cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_GATHER = 3'd1;
	localparam logic [2:0] S_FLUSH  = 3'd2;
	localparam logic [2:0] S_DIVLD  = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;
	localparam logic [2:0] S_BRD_RD = 3'd6;
	localparam logic [2:0] S_BRD_WT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = sts.slot_free;
				if (in_valid && sts.slot_free) begin
					cmd.accept    = 1'b1;
					cmd.clear_acc = 1'b1;
					if (sts.emit) begin
						state_d = sts.interior ? S_GATHER : S_BRD_RD;
					end
				end
			end
			S_GATHER: begin
				cmd.gather = 1'b1;
				if (sts.gather_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: state_d = S_DIVLD;
			S_DIVLD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.load_mean = 1'b1;
				state_d       = S_IDLE;
			end
			S_BRD_RD: begin
				cmd.brd_rd = 1'b1;
				state_d    = S_BRD_WT;
			end
			S_BRD_WT: begin
				cmd.load_border = 1'b1;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/baf_dp.sv @@
`default_nettype none
module baf_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [baf_pkg::SIZE_W-1:0]        cfg_wdata,
	input  wire logic                              in_cmd,
	input  wire logic [baf_pkg::PIX_W-1:0]         in_pixel,
	input  wire baf_pkg::cmd_t                     cmd,
	output      baf_pkg::status_t                  sts,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [baf_pkg::PIX_W-1:0]         out_value,
	output      logic                              out_last
);
	logic [baf_pkg::SIZE_W-1:0] size_q;
	logic [baf_pkg::SIZE_W-1:0] n;
	logic [baf_pkg::POS_W-1:0]  in_row_q, in_col_q, out_row_q, out_col_q;
	logic [baf_pkg::CNT_W-1:0]  pcnt_q;
	logic                       in_done_q;
	logic [baf_pkg::SIZE_W:0]   lag;
	logic                       pix_write, row_end, frame_end, last_px;
	logic [baf_pkg::SIZE_W-1:0] r10, c10;
	logic [2:0]                 dy_q, dx_q;
	logic                       acc_en_s1;
	logic signed [baf_pkg::ACC_W-1:0] acc_q, mag;
	logic [baf_pkg::MAG_W-1:0]  mag_q;
	logic                       neg_q;
	logic [baf_pkg::STEP_W-1:0] step_q;
	logic [baf_pkg::HALF_W-1:0] mul_a, mul_b;
	logic [2*baf_pkg::HALF_W-1:0] part;
	logic [baf_pkg::PROD_W-1:0] part_sh, prod_q;
	logic [baf_pkg::PIX_W-1:0]  quot;
	logic                       out_valid_q;
	logic                       load;
	logic [baf_pkg::LINE_W-1:0] rd_line;
	logic [baf_pkg::POS_W-1:0]  rd_col;
	logic [baf_pkg::ADDR_W-1:0] raddr, waddr;
	logic [baf_pkg::PIX_W-1:0]  rdata;

	always_comb begin
		n = size_q;
		if (size_q == '0) begin
			n = baf_pkg::SIZE_W'(1);
		end else if (size_q > baf_pkg::SIZE_W'(baf_pkg::MAX_SIZE)) begin
			n = baf_pkg::SIZE_W'(baf_pkg::MAX_SIZE);
		end
	end

	assign lag       = (baf_pkg::SIZE_W+1)'(n) * (baf_pkg::SIZE_W+1)'(baf_pkg::RADIUS)
	                 + (baf_pkg::SIZE_W+1)'(baf_pkg::RADIUS);
	assign pix_write = (in_cmd == baf_pkg::CMD_PIXEL) && !in_done_q;
	assign row_end   = ({1'b0, in_col_q} + 1'b1) >= n;
	assign frame_end = row_end && (({1'b0, in_row_q} + 1'b1) >= n);
	assign r10       = {1'b0, out_row_q};
	assign c10       = {1'b0, out_col_q};
	assign last_px   = (r10 + 1'b1 == n) && (c10 + 1'b1 == n);
	assign load      = cmd.load_border || cmd.load_mean;

	assign sts.emit        = pix_write ? (pcnt_q >= baf_pkg::CNT_W'(lag)) : in_done_q;
	assign sts.interior    = (r10 >= baf_pkg::SIZE_W'(baf_pkg::RADIUS))
	                      && (r10 + baf_pkg::SIZE_W'(baf_pkg::RADIUS) < n)
	                      && (c10 >= baf_pkg::SIZE_W'(baf_pkg::RADIUS))
	                      && (c10 + baf_pkg::SIZE_W'(baf_pkg::RADIUS) < n);
	assign sts.gather_last = (dy_q == 3'(baf_pkg::WIN - 1)) && (dx_q == 3'(baf_pkg::WIN - 1));
	assign sts.div_done    = step_q == baf_pkg::STEP_W'(baf_pkg::MUL_STEPS - 1);
	assign sts.slot_free   = !out_valid_q || out_ready;

	always_comb begin
		if (cmd.brd_rd) begin
			rd_line = out_row_q[baf_pkg::LINE_W-1:0];
			rd_col  = out_col_q;
		end else begin
			rd_line = out_row_q[baf_pkg::LINE_W-1:0] - baf_pkg::LINE_W'(baf_pkg::RADIUS)
			        + dy_q;
			rd_col  = out_col_q - baf_pkg::POS_W'(baf_pkg::RADIUS) + baf_pkg::POS_W'(dx_q);
		end
	end
	assign raddr = {rd_line, rd_col};
	assign waddr = {in_row_q[baf_pkg::LINE_W-1:0], in_col_q};

	baf_ram #(.WIDTH(baf_pkg::PIX_W), .DEPTH(baf_pkg::DEPTH)) u_lines (
		.clk   (clk),
		.we    (cmd.accept && pix_write),
		.waddr (waddr),
		.wdata (in_pixel),
		.re    (cmd.gather || cmd.brd_rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= baf_pkg::SIZE_W'(baf_pkg::MAX_SIZE);
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pcnt_q    <= '0;
			in_done_q <= 1'b0;
		end else if (cfg_we) begin
			size_q    <= cfg_wdata;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pcnt_q    <= '0;
			in_done_q <= 1'b0;
		end else begin
			if (cmd.accept && pix_write) begin
				pcnt_q <= pcnt_q + 1'b1;
				if (row_end) begin
					in_col_q <= '0;
					in_row_q <= frame_end ? '0 : in_row_q + 1'b1;
					if (frame_end) begin
						in_done_q <= 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (load) begin
				if (last_px) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					pcnt_q    <= '0;
					in_done_q <= 1'b0;
				end else if (c10 + 1'b1 >= n) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// window sweep and sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dy_q      <= '0;
			dx_q      <= '0;
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.gather;
			if (cmd.clear_acc) begin
				dy_q <= '0;
				dx_q <= '0;
			end else if (cmd.gather) begin
				if (dx_q == 3'(baf_pkg::WIN - 1)) begin
					dx_q <= '0;
					dy_q <= dy_q + 1'b1;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			acc_q <= '0;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + baf_pkg::ACC_W'(signed'(rdata));
		end
	end

	// divide by the window area: magnitude times a scaled reciprocal,
	// one 19x19 partial product a cycle
	assign mag  = acc_q[baf_pkg::ACC_W-1] ? -acc_q : acc_q;
	assign part = (2*baf_pkg::HALF_W)'(mul_a) * (2*baf_pkg::HALF_W)'(mul_b);
	assign quot = neg_q ? -prod_q[baf_pkg::PROD_W-1:baf_pkg::RECIP_SH]
	                    : prod_q[baf_pkg::PROD_W-1:baf_pkg::RECIP_SH];

	always_comb begin
		mul_a = step_q[1] ? baf_pkg::HALF_W'(mag_q[baf_pkg::MAG_W-1:baf_pkg::HALF_W])
		                  : mag_q[baf_pkg::HALF_W-1:0];
		mul_b = step_q[0] ? baf_pkg::RECIP[baf_pkg::RECIP_W-1:baf_pkg::HALF_W]
		                  : baf_pkg::RECIP[baf_pkg::HALF_W-1:0];
		case (step_q)
			2'd0:    part_sh = baf_pkg::PROD_W'(part);
			2'd3:    part_sh = baf_pkg::PROD_W'(part) << (2 * baf_pkg::HALF_W);
			default: part_sh = baf_pkg::PROD_W'(part) << baf_pkg::HALF_W;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			mag_q  <= mag[baf_pkg::MAG_W-1:0];
			neg_q  <= acc_q[baf_pkg::ACC_W-1];
			step_q <= '0;
			prod_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
			prod_q <= prod_q + part_sh;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value <= cmd.load_mean ? quot : rdata;
			out_last  <= last_px;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

@@ rtl/core/box_average_filter_7x7.sv @@
`default_nettype none
// 7x7 box mean filter over a square raster image of signed 32-bit pixels.
// pix: input beats, cmd 0 carries a pixel, cmd 1 is a drain tick.
// res: result beats, out_value with out_last set on the final pixel.
// cfg_we/cfg_wdata: writes image_size (0 acts as 1, above 512 as 512);
//   a write restarts the frame. Write only while the block is idle.
// Results trail input by 3 rows plus 3 pixels; after the frame's last
//   pixel, drain ticks pull out the rest, one result per tick.
// Work per input beat:
//   no result: the beat is only taken; border result: one line store read;
//   interior result: 49 window reads on the line store's single
//   read port, a flush step, then a 4-step reciprocal multiply for /49.
// One beat is in work at a time; the next is taken once the output
//   register is empty or being read in that cycle, and is held off while
//   res stalls with a result still pending.
// Reset: image_size 512, counters cleared, no result pending. The line
//   store needs no clearing pass.
module box_average_filter_7x7 (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [baf_pkg::SIZE_W-1:0]  cfg_wdata,
	baf_in_if.sink                           pix,
	baf_out_if.source                        res
);
	baf_pkg::cmd_t    cmd;
	baf_pkg::status_t sts;

	baf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	baf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_cmd    (pix.cmd),
		.in_pixel  (pix.pixel_value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_value (res.out_value),
		.out_last  (res.out_last)
	);
endmodule
`default_nettype wire
